FILE: src/csc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, codes and helpers of the snooping coherence controller.
// ----------------------------------------------------------------------------
package csc_pkg;

	localparam int LINE_INDEX_W     = 10;
	localparam int CFG_W            = 4;
	localparam int DEF_NUM_LINES    = 1024;
	localparam int DEF_COUNTER_BITS = 4;
	localparam logic [CFG_W-1:0] COUNTER_INIT_RESET = 4'd1;

	typedef enum logic [2:0] {
		LS_I  = 3'd0,
		LS_E  = 3'd1,
		LS_SC = 3'd2,
		LS_SM = 3'd3,
		LS_M  = 3'd4
	} line_state_t;

	typedef enum logic [2:0] {
		MODE_PROC_RD    = 3'd0,
		MODE_PROC_WR    = 3'd1,
		MODE_BUS_DONE   = 3'd2,
		MODE_SNOOP_RD   = 3'd3,
		MODE_SNOOP_UPDT = 3'd4,
		MODE_FILL_DONE  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		BUS_NONE        = 2'd0,
		BUS_RD          = 2'd1,
		BUS_UPDT        = 2'd2,
		BUS_UPDT_FOLLOW = 2'd3
	} bus_op_t;

	typedef enum logic [1:0] {
		FSM_CLEAR = 2'd0,
		FSM_IDLE  = 2'd1,
		FSM_EXEC  = 2'd2
	} fsm_state_t;

	// outstanding request and fill flags
	typedef struct packed {
		logic        fill_pending;
		logic        req_outstanding;
		logic        req_is_write;
		line_state_t req_old_state;
	} ctrl_flags_t;

	// result item, hit in the lowest bit
	typedef struct packed {
		logic        error;
		line_state_t line_state;
		logic        assert_owner;
		logic        assert_shared;
		logic        cache_transfer;
		logic        mem_fetch;
		bus_op_t     bus_op;
		logic        hit;
	} resp_t;

	localparam int RESP_W = $bits(resp_t);

	// number of conditional-subtract steps that reduce a line index
	// modulo n (zero when n covers the whole index range)
	function automatic int mod_steps(input int n);
		int s;
		s = 0;
		for (int k = 0; k < LINE_INDEX_W + 1; k++) begin
			if ((n << k) <= (1 << LINE_INDEX_W) - 1) begin
				s = k + 1;
			end
		end
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: src/csc_line_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csc_line_mem
// Line state / use counter memory, one read and one write port, registered
// read data, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module csc_line_mem
	import csc_pkg::*;
#(
	parameter int NUM_LINES = DEF_NUM_LINES,
	parameter int WORD_W    = 3 + DEF_COUNTER_BITS,
	localparam int IDX_W    = $clog2(NUM_LINES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [IDX_W-1:0]  rd_addr,
	output logic      [WORD_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_addr,
	input  wire logic [WORD_W-1:0] wr_data,
	output logic                   init_busy
);

	logic [WORD_W-1:0] mem [NUM_LINES];
	logic [WORD_W-1:0] rd_data_q;
	logic [IDX_W-1:0]  clr_addr_q;
	logic              clr_busy_q;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [WORD_W-1:0] wdata;

	assign we    = clr_busy_q | wr_en;
	assign waddr = clr_busy_q ? clr_addr_q : wr_addr;
	assign wdata = clr_busy_q ? '0 : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_addr_q == IDX_W'(NUM_LINES - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data   = rd_data_q;
	assign init_busy = clr_busy_q;

endmodule
`default_nettype wire

FILE: src/csc_protocol.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csc_protocol
// Coherence transition logic: from the line read out of memory, the event
// and the request/fill registers, forms the line write-back, the response
// and the next request/fill registers.
// ----------------------------------------------------------------------------
module csc_protocol
	import csc_pkg::*;
#(
	parameter int NUM_LINES    = DEF_NUM_LINES,
	parameter int COUNTER_BITS = DEF_COUNTER_BITS,
	localparam int IDX_W       = $clog2(NUM_LINES)
) (
	input  wire mode_t                   mode,
	input  wire logic [IDX_W-1:0]        line,
	input  wire logic                    bus_shared,
	input  wire logic                    bus_owner,
	input  wire logic [CFG_W-1:0]        counter_init,
	input  wire line_state_t             rd_state,
	input  wire logic [COUNTER_BITS-1:0] rd_cnt,
	input  wire ctrl_flags_t             ctrl,
	input  wire logic [IDX_W-1:0]        fill_index,
	input  wire logic [IDX_W-1:0]        req_index,
	output line_state_t                  wr_state,
	output logic      [COUNTER_BITS-1:0] wr_cnt,
	output resp_t                        resp,
	output ctrl_flags_t                  ctrl_next,
	output logic      [IDX_W-1:0]        fill_index_next,
	output logic      [IDX_W-1:0]        req_index_next
);

	localparam int SAT_W = CFG_W + COUNTER_BITS;
	localparam logic [SAT_W-1:0] CNT_MAX = (SAT_W'(1) << COUNTER_BITS) - SAT_W'(1);

	logic [COUNTER_BITS-1:0] init_sat;
	logic [COUNTER_BITS-1:0] cnt_bumped;
	logic                    filling;
	logic                    is_wr;

	always_comb begin
		if (SAT_W'(counter_init) > CNT_MAX) begin
			init_sat = CNT_MAX[COUNTER_BITS-1:0];
		end else begin
			init_sat = COUNTER_BITS'(counter_init);
		end
	end

	assign cnt_bumped = (rd_cnt != '1) ? rd_cnt + 1'b1 : rd_cnt;
	assign filling    = ctrl.fill_pending && (fill_index == line);
	assign is_wr      = (mode == MODE_PROC_WR);

	always_comb begin
		wr_state        = rd_state;
		wr_cnt          = rd_cnt;
		resp            = '0;
		ctrl_next       = ctrl;
		fill_index_next = fill_index;
		req_index_next  = req_index;

		case (mode)
			MODE_PROC_RD, MODE_PROC_WR: begin
				if (rd_state == LS_M || (!is_wr && rd_state != LS_I)) begin
					resp.hit = 1'b1;
					wr_cnt   = cnt_bumped;
				end else if (is_wr && rd_state == LS_E) begin
					resp.hit = 1'b1;
					wr_cnt   = cnt_bumped;
					wr_state = LS_M;
				end else if (ctrl.req_outstanding) begin
					resp.error = 1'b1;
				end else begin
					if (rd_state != LS_I) begin
						wr_cnt = cnt_bumped;
					end
					resp.bus_op               = (rd_state == LS_I) ? BUS_RD : BUS_UPDT;
					ctrl_next.req_outstanding = 1'b1;
					ctrl_next.req_is_write    = is_wr;
					ctrl_next.req_old_state   = rd_state;
					req_index_next            = line;
				end
			end
			MODE_BUS_DONE: begin
				if (!ctrl.req_outstanding) begin
					resp.error = 1'b1;
				end else begin
					ctrl_next.req_outstanding = 1'b0;
					if (ctrl.req_old_state == LS_I) begin
						if (bus_owner) begin
							resp.cache_transfer = 1'b1;
						end else begin
							resp.mem_fetch         = 1'b1;
							ctrl_next.fill_pending = 1'b1;
							fill_index_next        = line;
						end
						wr_cnt = init_sat;
						if (!ctrl.req_is_write) begin
							wr_state = bus_shared ? LS_SC : LS_E;
						end else if (!bus_shared) begin
							wr_state = LS_M;
						end else begin
							wr_state    = LS_SM;
							resp.bus_op = BUS_UPDT_FOLLOW;
						end
					end else if (ctrl.req_is_write &&
						(ctrl.req_old_state == LS_SC || ctrl.req_old_state == LS_SM)) begin
						if (!bus_shared) begin
							wr_state = LS_M;
						end else begin
							resp.cache_transfer = 1'b1;
							wr_state            = LS_SM;
						end
					end else begin
						resp.error = 1'b1;
					end
				end
			end
			MODE_SNOOP_RD: begin
				if (rd_state == LS_M) begin
					wr_state           = LS_SM;
					resp.assert_owner  = 1'b1;
					resp.assert_shared = 1'b1;
				end else if (rd_state == LS_SM) begin
					resp.assert_owner  = 1'b1;
					resp.assert_shared = 1'b1;
				end else if (rd_state == LS_SC || rd_state == LS_E) begin
					resp.assert_owner  = !filling;
					resp.assert_shared = 1'b1;
					wr_state           = LS_SC;
				end
			end
			MODE_SNOOP_UPDT: begin
				if (rd_state == LS_M || rd_state == LS_E) begin
					resp.error = 1'b1;
				end else if (rd_state == LS_SM || rd_state == LS_SC) begin
					resp.assert_owner = (rd_state == LS_SC) && !filling;
					// competitive update: drop the copy once its count runs out
					if (rd_cnt <= COUNTER_BITS'(1)) begin
						wr_state = LS_I;
					end else begin
						wr_cnt             = rd_cnt - 1'b1;
						wr_state           = LS_SC;
						resp.assert_shared = 1'b1;
					end
				end
			end
			MODE_FILL_DONE: begin
				if (ctrl.fill_pending) begin
					ctrl_next.fill_pending = 1'b0;
				end else begin
					resp.error = 1'b1;
				end
			end
			default: begin
				resp.error = 1'b1;
			end
		endcase

		resp.line_state = wr_state;
	end

endmodule
`default_nettype wire

FILE: src/competitive_snoop_coherence_ctrl_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// competitive_snoop_coherence_ctrl_top
// Per-cache controller of a five-state competitive-update snooping protocol.
// ----------------------------------------------------------------------------
// Timing: an accepted event is held while its line is read, then its result is
//   registered into the output register once that register can take it; no new
//   event is accepted until then, as s_tready is high only in the idle state.
// Reset: request/fill registers clear at once and counter_init returns to 1;
//   a clearing sweep then zeroes the line memory, with s_tready low until the
//   sweep has ended. Configuration writes are taken during the sweep.
// ----------------------------------------------------------------------------
module competitive_snoop_coherence_ctrl_top
	import csc_pkg::*;
#(
	parameter int NUM_LINES    = DEF_NUM_LINES,
	parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// event channel
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // line_index[9:0], bus_shared[10], bus_owner[11]
	input  wire logic [2:0]  s_tuser,   // mode[2:0]
	// result channel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // hit[0], bus_op[2:1], mem_fetch[3],
	                                    // cache_transfer[4], assert_shared[5],
	                                    // assert_owner[6], line_state_out[9:7],
	                                    // error[10]
	// counter_init register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data
);

	localparam int IDX_W     = $clog2(NUM_LINES);
	localparam int WORD_W    = 3 + COUNTER_BITS;
	localparam int MOD_STEPS = mod_steps(NUM_LINES);

	// ---------------- state ----------------
	fsm_state_t              state_q, state_d;
	logic [CFG_W-1:0]        counter_init_q;
	ctrl_flags_t             ctrl_q;
	logic [IDX_W-1:0]        fill_index_q;
	logic [IDX_W-1:0]        req_index_q;

	// event held while its line is read and updated
	mode_t                   mode_s1;
	logic [IDX_W-1:0]        addr_s1;
	logic                    shared_s1;
	logic                    owner_s1;

	// output register
	logic                    m_tvalid_q;
	resp_t                   resp_q;

	// ---------------- control ----------------
	logic                    accept;
	logic                    commit;
	logic                    init_busy;

	logic [LINE_INDEX_W-1:0] idx_red;
	logic [IDX_W-1:0]        rd_addr;

	logic [WORD_W-1:0]       rd_word;
	line_state_t             wr_state;
	logic [COUNTER_BITS-1:0] wr_cnt;
	resp_t                   resp_c;
	ctrl_flags_t             ctrl_next;
	logic [IDX_W-1:0]        fill_index_next;
	logic [IDX_W-1:0]        req_index_next;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid & s_tready;

	// line_index modulo NUM_LINES by conditional subtraction of shifted copies
	always_comb begin
		idx_red = s_tdata[LINE_INDEX_W-1:0];
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (idx_red >= LINE_INDEX_W'(NUM_LINES << k)) begin
				idx_red = idx_red - LINE_INDEX_W'(NUM_LINES << k);
			end
		end
	end

	// bus-done and fill-done address the recorded line, not line_index
	always_comb begin
		case (mode_t'(s_tuser))
			MODE_BUS_DONE:  rd_addr = req_index_q;
			MODE_FILL_DONE: rd_addr = fill_index_q;
			default:        rd_addr = IDX_W'(idx_red);
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_CLEAR: begin
				if (!init_busy) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (s_tvalid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (commit) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_CLEAR;
			end
		endcase
	end

	// FSM outputs; commit waits until the output register can take the result
	always_comb begin
		s_tready = 1'b0;
		commit   = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
			end
			FSM_EXEC: begin
				commit = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= FSM_CLEAR;
			counter_init_q <= COUNTER_INIT_RESET;
			ctrl_q         <= '{fill_pending: 1'b0, req_outstanding: 1'b0,
			                    req_is_write: 1'b0, req_old_state: LS_I};
			fill_index_q   <= '0;
			req_index_q    <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				counter_init_q <= cfg_data;
			end
			if (commit) begin
				ctrl_q       <= ctrl_next;
				fill_index_q <= fill_index_next;
				req_index_q  <= req_index_next;
			end
			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= mode_t'(s_tuser);
			addr_s1   <= rd_addr;
			shared_s1 <= s_tdata[LINE_INDEX_W];
			owner_s1  <= s_tdata[LINE_INDEX_W+1];
		end
		if (commit) begin
			resp_q <= resp_c;
		end
	end

	// ---------------- datapath ----------------
	csc_line_mem #(
		.NUM_LINES (NUM_LINES),
		.WORD_W    (WORD_W)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr   (rd_addr),
		.rd_data   (rd_word),
		.wr_en     (commit),
		.wr_addr   (addr_s1),
		.wr_data   ({wr_state, wr_cnt}),
		.init_busy (init_busy)
	);

	csc_protocol #(
		.NUM_LINES    (NUM_LINES),
		.COUNTER_BITS (COUNTER_BITS)
	) u_proto (
		.mode            (mode_s1),
		.line            (addr_s1),
		.bus_shared      (shared_s1),
		.bus_owner       (owner_s1),
		.counter_init    (counter_init_q),
		.rd_state        (line_state_t'(rd_word[WORD_W-1 -: 3])),
		.rd_cnt          (rd_word[COUNTER_BITS-1:0]),
		.ctrl            (ctrl_q),
		.fill_index      (fill_index_q),
		.req_index       (req_index_q),
		.wr_state        (wr_state),
		.wr_cnt          (wr_cnt),
		.resp            (resp_c),
		.ctrl_next       (ctrl_next),
		.fill_index_next (fill_index_next),
		.req_index_next  (req_index_next)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(16 - RESP_W)'(0), resp_q};

endmodule
`default_nettype wire
